/* rtl/core/apm_pkg.sv */
// ----------------------------------------------------------------------------
// apm_pkg
// Shared types, codes and constants for the acknowledge packet matcher.
// ----------------------------------------------------------------------------
package apm_pkg;

    localparam int PKT_LEN  = 10;
    localparam int MATCH_W  = 4;
    localparam int TICK_W   = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    // input function codes
    localparam logic [1:0] FUNC_START = 2'd0;
    localparam logic [1:0] FUNC_BYTE  = 2'd1;
    localparam logic [1:0] FUNC_TICK  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ACK_CLASS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACK_MSG_ID = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_MS = 2'd2;

    localparam logic [7:0]        RST_ACK_CLASS  = 8'd6;
    localparam logic [7:0]        RST_ACK_MSG_ID = 8'd36;
    localparam logic [TICK_W-1:0] RST_TIMEOUT_MS = 16'd3000;

    localparam logic [7:0] PKT_SYNC1 = 8'hB5;
    localparam logic [7:0] PKT_SYNC2 = 8'h62;
    localparam logic [7:0] PKT_CLASS = 8'h05;
    localparam logic [7:0] PKT_ID    = 8'h01;
    localparam logic [7:0] PKT_LEN_L = 8'h02;
    localparam logic [7:0] PKT_LEN_H = 8'h00;

    // checksum contribution of the fixed bytes 2..5
    localparam logic [7:0] CK_A_BASE = 8'(5 + 1 + 2 + 0);
    localparam logic [7:0] CK_B_BASE = 8'(5 + 6 + 8 + 8 + 8 + 8);

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_WAIT = 2'd1,
        PH_OK   = 2'd2,
        PH_FAIL = 2'd3
    } t_phase;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         status;
        logic [MATCH_W-1:0] matched_count;
    } t_out_item;

    typedef struct packed {
        logic [7:0]        ack_class;
        logic [7:0]        ack_msg_id;
        logic [TICK_W-1:0] timeout_ms;
        logic [7:0]        ck_a;
        logic [7:0]        ck_b;
    } t_cfg;

    function automatic logic [7:0] expected_byte(logic [MATCH_W-1:0] pos, t_cfg cfg);
        logic [7:0] b;
        case (pos)
            4'd0:    b = PKT_SYNC1;
            4'd1:    b = PKT_SYNC2;
            4'd2:    b = PKT_CLASS;
            4'd3:    b = PKT_ID;
            4'd4:    b = PKT_LEN_L;
            4'd5:    b = PKT_LEN_H;
            4'd6:    b = cfg.ack_class;
            4'd7:    b = cfg.ack_msg_id;
            4'd8:    b = cfg.ck_a;
            4'd9:    b = cfg.ck_b;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

/* rtl/core/apm_cfg_regs.sv */
// ----------------------------------------------------------------------------
// apm_cfg_regs
// Configuration registers and the derived Fletcher checksum bytes.
// ----------------------------------------------------------------------------
module apm_cfg_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    input  logic [apm_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [apm_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output apm_pkg::t_cfg                     o_cfg
);

    logic [7:0]                  r_ack_class;
    logic [7:0]                  r_ack_msg_id;
    logic [apm_pkg::TICK_W-1:0]  r_timeout_ms;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ack_class  <= apm_pkg::RST_ACK_CLASS;
            r_ack_msg_id <= apm_pkg::RST_ACK_MSG_ID;
            r_timeout_ms <= apm_pkg::RST_TIMEOUT_MS;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                apm_pkg::CFG_ACK_CLASS:  r_ack_class  <= i_cfg_data[7:0];
                apm_pkg::CFG_ACK_MSG_ID: r_ack_msg_id <= i_cfg_data[7:0];
                apm_pkg::CFG_TIMEOUT_MS: r_timeout_ms <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        o_cfg.ack_class  = r_ack_class;
        o_cfg.ack_msg_id = r_ack_msg_id;
        o_cfg.timeout_ms = r_timeout_ms;
        o_cfg.ck_a       = apm_pkg::CK_A_BASE + r_ack_class + r_ack_msg_id;
        o_cfg.ck_b       = apm_pkg::CK_B_BASE + {r_ack_class[6:0], 1'b0} + r_ack_msg_id;
    end

endmodule

/* rtl/core/apm_step.sv */
// ----------------------------------------------------------------------------
// apm_step
// Wait state, match index and elapsed tick counter; one item per fire.
// ----------------------------------------------------------------------------
module apm_step (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  apm_pkg::t_in_item   i_item,
    input  apm_pkg::t_cfg       i_cfg,
    output apm_pkg::t_out_item  o_result
);

    apm_pkg::t_phase               r_phase, n_phase;
    logic [apm_pkg::MATCH_W-1:0]   r_match_index, n_match_index;
    logic [apm_pkg::TICK_W-1:0]    r_elapsed, n_elapsed;

    logic                          byte_hit;
    logic [apm_pkg::MATCH_W-1:0]   index_inc;
    logic [apm_pkg::TICK_W-1:0]    elapsed_inc;
    logic                          waiting;

    assign waiting     = (r_phase == apm_pkg::PH_WAIT);
    assign byte_hit    = (r_match_index < apm_pkg::MATCH_W'(apm_pkg::PKT_LEN)) &&
                         (i_item.rx_byte == apm_pkg::expected_byte(r_match_index, i_cfg));
    assign index_inc   = r_match_index + 1'b1;
    assign elapsed_inc = (r_elapsed == '1) ? r_elapsed : r_elapsed + 1'b1;

    // next state
    always_comb begin
        n_phase = r_phase;
        case (i_item.func)
            apm_pkg::FUNC_START: n_phase = apm_pkg::PH_WAIT;
            apm_pkg::FUNC_BYTE: begin
                if (waiting && byte_hit &&
                    index_inc >= apm_pkg::MATCH_W'(apm_pkg::PKT_LEN)) begin
                    n_phase = apm_pkg::PH_OK;
                end
            end
            apm_pkg::FUNC_TICK: begin
                if (waiting && elapsed_inc > i_cfg.timeout_ms) begin
                    n_phase = apm_pkg::PH_FAIL;
                end
            end
            default: ;
        endcase
    end

    // counters
    always_comb begin
        n_match_index = r_match_index;
        n_elapsed     = r_elapsed;
        case (i_item.func)
            apm_pkg::FUNC_START: begin
                n_match_index = '0;
                n_elapsed     = '0;
            end
            apm_pkg::FUNC_BYTE: begin
                if (waiting) begin
                    n_match_index = byte_hit ? index_inc : '0;
                end
            end
            apm_pkg::FUNC_TICK: begin
                if (waiting) begin
                    n_elapsed = elapsed_inc;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= apm_pkg::PH_IDLE;
            r_match_index <= '0;
            r_elapsed     <= '0;
        end else if (i_fire) begin
            r_phase       <= n_phase;
            r_match_index <= n_match_index;
            r_elapsed     <= n_elapsed;
        end
    end

    assign o_result.status        = n_phase;
    assign o_result.matched_count = n_match_index;

endmodule

/* rtl/core/ack_packet_matcher_core.sv */
// ----------------------------------------------------------------------------
// ack_packet_matcher_core
// Acknowledge packet matcher: input register, state update, result
// register. The result beat is registered in the result register when its
// item leaves the input register. Throughput: one item per cycle, limited
// only by output stall. Reset: synchronous active low; phase idle, counters
// zero, registers at their defaults (class 6, id 36, timeout 3000).
// ----------------------------------------------------------------------------
module ack_packet_matcher_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    input  apm_pkg::t_in_item                 i_in_data,
    output logic                              o_in_stall,
    output logic                              o_out_valid,
    output apm_pkg::t_out_item                o_out_data,
    input  logic                              i_out_stall,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [apm_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [apm_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    logic                r_in_valid;
    apm_pkg::t_in_item   r_in_item;
    logic                r_out_valid;
    apm_pkg::t_out_item  r_out_item;

    apm_pkg::t_cfg       cfg;
    apm_pkg::t_out_item  result;
    logic                advance;
    logic                fire;
    logic                in_take;

    assign o_cfg_ready = 1'b1;

    assign advance    = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && advance;
    assign o_in_stall = r_in_valid && !advance;
    assign in_take    = i_in_valid && !o_in_stall;

    apm_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    apm_step u_step (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (r_in_item),
        .i_cfg    (cfg),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_item <= i_in_data;
        end
        if (fire) begin
            r_out_item <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_item;

endmodule
